// ===== sv/mcbf_pkg.sv =====
// Shared types and constants for the mipmap chain box filter.
// No dependencies; used by mcbf_ctrl, mcbf_datapath and the top level.
`default_nettype none
package mcbf_pkg;

    localparam int MAX_DIM     = 2048;
    localparam int MAX_LEVELS  = 12;
    localparam int STORE_DEPTH = MAX_DIM + MAX_LEVELS;
    localparam int DIM_W       = 12;
    localparam int COORD_W     = 11;
    localparam int LEVEL_W     = 4;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam logic [1:0] CFG_SOURCE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SOURCE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_SWAP_RED_BLUE = 2'd2;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [7:0] in_alpha;
    } in_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] mip_level;
        logic [COORD_W-1:0] pixel_column;
        logic [COORD_W-1:0] pixel_row;
        logic [7:0]         out_red;
        logic [7:0]         out_green;
        logic [7:0]         out_blue;
        logic [7:0]         out_alpha;
        logic               run_end;
        logic               chain_done;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic calc;
        logic emit;
        logic idle;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic more;
    } status_t;

    // Size of a level: source size shifted down, never below one.
    function automatic logic [DIM_W-1:0] level_dim(input logic [DIM_W-1:0] d,
                                                   input logic [LEVEL_W-1:0] l);
        logic [DIM_W-1:0] s;
        s = d >> l;
        return (s == '0) ? DIM_W'(1) : s;
    endfunction

endpackage
`default_nettype wire

// ===== sv/mcbf_ctrl.sv =====
// Sequencer for the mipmap chain box filter: accept, compute, emit per level.
// Depends on mcbf_pkg.
`default_nettype none
module mcbf_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire mcbf_pkg::status_t status,
    output mcbf_pkg::cmd_t        cmd
);

    typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_EMIT} state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.idle = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.more ? ST_CALC : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef SYNTHESIS
    a_load_then_calc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.calc) else $error("calc did not follow load");
    a_calc_then_emit_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.calc |=> !cmd.calc && !cmd.idle) else $error("calc not followed by emit");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.calc, cmd.emit})) else $error("overlapping commands");
`endif

endmodule
`default_nettype wire

// ===== sv/mcbf_datapath.sv =====
// Datapath of the mipmap chain box filter: config, level positions, held
// pixels, pair-sum line buffer memory and output register. Depends on mcbf_pkg.
`default_nettype none
module mcbf_datapath (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire mcbf_pkg::cmd_t         cmd,
    output mcbf_pkg::status_t           status,
    input  wire mcbf_pkg::in_item_t     in_item,
    input  wire logic                   cfg_valid,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [11:0]            cfg_data,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output mcbf_pkg::out_item_t         out_item
);

    localparam int LW = mcbf_pkg::LEVEL_W;
    localparam int DW = mcbf_pkg::DIM_W;
    localparam int CW = mcbf_pkg::COORD_W;
    localparam int AW = mcbf_pkg::ADDR_W;

    logic [DW-1:0] width_reg, height_reg;
    logic          swap_reg;
    logic [LW-1:0] lvl_reg;
    logic [DW-1:0] off_reg;
    logic          final_reg;
    logic [31:0]   pix_reg;
    logic [CW-1:0] col_reg [mcbf_pkg::MAX_LEVELS];
    logic [CW-1:0] row_reg [mcbf_pkg::MAX_LEVELS];
    logic [31:0]   held_reg [mcbf_pkg::MAX_LEVELS];
    logic [35:0]   mem [mcbf_pkg::STORE_DEPTH];
    logic [35:0]   rdata_reg, pair_reg;
    logic [AW-1:0] idx_reg;
    logic          store_reg, fold_reg, dbl_reg;
    logic [DW-1:0] dw_reg;
    logic [CW-1:0] x_reg, y_reg;
    logic          out_valid_reg;
    mcbf_pkg::out_item_t out_item_reg;

    logic [DW-1:0] wc, hc, sw, sh, dw, dh, idx_full, dx;
    logic [CW-1:0] x, y, nx, ny;
    logic [LW-1:0] lvl_up;
    logic          last, xin, yin, have;
    logic [35:0]   pair;
    logic [31:0]   newpix;
    logic          cfg_we, clear_pos, more, cfg_known;
    logic [9:0]    total [4];

    assign cfg_we = cfg_valid && cmd.idle;
    assign wc = (width_reg == '0) ? DW'(1) :
                (width_reg > DW'(mcbf_pkg::MAX_DIM)) ? DW'(mcbf_pkg::MAX_DIM) : width_reg;
    assign hc = (height_reg == '0) ? DW'(1) :
                (height_reg > DW'(mcbf_pkg::MAX_DIM)) ? DW'(mcbf_pkg::MAX_DIM) : height_reg;

    always_comb
    begin
        lvl_up = lvl_reg + LW'(1);
        sw   = mcbf_pkg::level_dim(wc, lvl_reg);
        sh   = mcbf_pkg::level_dim(hc, lvl_reg);
        dw   = mcbf_pkg::level_dim(wc, lvl_up);
        dh   = mcbf_pkg::level_dim(hc, lvl_up);
        x    = col_reg[lvl_reg];
        y    = row_reg[lvl_reg];
        last = (sw == DW'(1) && sh == DW'(1)) ||
               (lvl_reg == LW'(mcbf_pkg::MAX_LEVELS - 1));
        xin  = (sw == DW'(1)) || ({1'b0, x} < {dw[DW-2:0], 1'b0});
        have = !last && ((sw == DW'(1)) || (xin && x[0]));
        dx   = (sw == DW'(1)) ? '0 : DW'(x >> 1);
        idx_full = off_reg + dx;
        yin  = ({1'b0, y} < {dh[DW-2:0], 1'b0}) &&
               (idx_full < DW'(mcbf_pkg::STORE_DEPTH));
        for (int c = 0; c < 4; c++)
        begin
            if (sw == DW'(1))
                pair[c*9 +: 9] = {pix_reg[c*8 +: 8], 1'b0};
            else
                pair[c*9 +: 9] = {1'b0, held_reg[lvl_reg][c*8 +: 8]} +
                                 {1'b0, pix_reg[c*8 +: 8]};
        end
        // Advance the raster position of this level; compare at full width
        // so a 2048-wide level still wraps to the next row.
        nx = x + CW'(1);
        ny = y;
        if (({1'b0, x} + DW'(1)) >= sw)
        begin
            nx = '0;
            ny = y + CW'(1);
            if (({1'b0, y} + DW'(1)) >= sh)
                ny = '0;
        end
    end

    always_comb
    begin
        more = fold_reg || dbl_reg;
        for (int c = 0; c < 4; c++)
        begin
            if (dbl_reg)
                total[c] = {pair_reg[c*9 +: 9], 1'b0};
            else
                total[c] = {1'b0, rdata_reg[c*9 +: 9]} + {1'b0, pair_reg[c*9 +: 9]};
            newpix[c*8 +: 8] = 8'((11'(total[c]) + 11'd2) >> 2);
        end
    end

    assign cfg_known = (cfg_index == mcbf_pkg::CFG_SOURCE_WIDTH) ||
                       (cfg_index == mcbf_pkg::CFG_SOURCE_HEIGHT) ||
                       (cfg_index == mcbf_pkg::CFG_SWAP_RED_BLUE);
    assign clear_pos = (cfg_we && cfg_known) ||
                       (cmd.emit && !more && final_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= DW'(1);
            height_reg    <= DW'(1);
            swap_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            lvl_reg       <= '0;
            for (int l = 0; l < mcbf_pkg::MAX_LEVELS; l++)
            begin
                col_reg[l] <= '0;
                row_reg[l] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    mcbf_pkg::CFG_SOURCE_WIDTH:  width_reg  <= cfg_data;
                    mcbf_pkg::CFG_SOURCE_HEIGHT: height_reg <= cfg_data;
                    mcbf_pkg::CFG_SWAP_RED_BLUE: swap_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
            if (cmd.load)
                lvl_reg <= '0;
            else if (cmd.emit && more)
                lvl_reg <= lvl_up;
            if (cmd.calc)
            begin
                col_reg[lvl_reg] <= nx;
                row_reg[lvl_reg] <= ny;
            end
            if (clear_pos)
            begin
                for (int l = 0; l < mcbf_pkg::MAX_LEVELS; l++)
                begin
                    col_reg[l] <= '0;
                    row_reg[l] <= '0;
                end
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pix_reg   <= swap_reg ?
                {in_item.in_blue, in_item.in_green, in_item.in_red, in_item.in_alpha} :
                {in_item.in_red, in_item.in_green, in_item.in_blue, in_item.in_alpha};
            off_reg   <= '0;
            final_reg <= ({1'b0, col_reg[0]} + DW'(1) >= wc) &&
                         ({1'b0, row_reg[0]} + DW'(1) >= hc);
        end
        if (cmd.calc)
        begin
            x_reg     <= x;
            y_reg     <= y;
            pair_reg  <= pair;
            idx_reg   <= AW'(idx_full);
            dw_reg    <= dw;
            dbl_reg   <= have && (sh == DW'(1));
            store_reg <= have && (sh != DW'(1)) && yin && !y[0];
            fold_reg  <= have && (sh != DW'(1)) && yin && y[0];
            rdata_reg <= mem[AW'(idx_full)];
            if (!last && sw != DW'(1) && xin && !x[0])
                held_reg[lvl_reg] <= pix_reg;
        end
        if (cmd.emit)
        begin
            if (store_reg)
                mem[idx_reg] <= pair_reg;
            out_item_reg <= '{mip_level: lvl_reg, pixel_column: x_reg, pixel_row: y_reg,
                              out_red: pix_reg[31:24], out_green: pix_reg[23:16],
                              out_blue: pix_reg[15:8], out_alpha: pix_reg[7:0],
                              run_end: !more, chain_done: !more && final_reg};
            if (more)
            begin
                pix_reg <= newpix;
                off_reg <= off_reg + dw_reg;
            end
        end
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign status.more     = more;
    assign out_valid       = out_valid_reg;
    assign out_item        = out_item_reg;

`ifndef SYNTHESIS
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        lvl_reg < LW'(mcbf_pkg::MAX_LEVELS)) else $error("level out of range");
    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.chain_done |-> out_item_reg.run_end)
        else $error("chain_done without run_end");
    a_single_path: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> $onehot0({store_reg, fold_reg, dbl_reg}))
        else $error("conflicting fold decisions");
`endif

endmodule
`default_nettype wire

// ===== sv/mipmap_chain_box_filter.sv =====
// Top level of the mipmap chain box filter.
// Depends on mcbf_pkg, mcbf_ctrl and mcbf_datapath.
//
// Usage:
//   in channel  : in_valid / in_stall / in_item, one level-0 RGBA8 pixel per
//                 item, raster order.
//   out channel : out_valid / out_stall / out_item, one result pixel per item
//                 with its mip level and coordinates; run_end marks the last
//                 result of an input pixel, chain_done the last of an image.
//   cfg channel : cfg_valid / cfg_ready / cfg_index / cfg_data; index 0 is the
//                 source width, 1 the source height, 2 the red/blue swap.
//                 A write to any of these restarts the image at the next pixel.
//                 A pending write wins over a pixel offered in the same cycle.
// Sequence: an input pixel takes an accept step plus, per result, a compute
//   step (position/pair compute with line buffer read) and a fold and emit
//   step; the emit step holds while a stalled result occupies the output register.
// Reset: configuration returns to a 1x1 image without swap, all level
//   positions clear; line buffer and held pixels need no clearing.
// Stall: a result waits in the output register; the sequencer holds in its
//   emit step and keeps in_stall high until the output register frees.
`default_nettype none
module mipmap_chain_box_filter (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire mcbf_pkg::in_item_t in_item,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output mcbf_pkg::out_item_t     out_item,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [11:0]        cfg_data
);

    mcbf_pkg::cmd_t    cmd;
    mcbf_pkg::status_t status;
    logic              pixel_req;

    // Hold pixels back while a register write is offered.
    assign pixel_req = in_valid && !cfg_valid;

    mcbf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixel_req),
        .status   (status),
        .cmd      (cmd)
    );

    mcbf_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // Take pixels and register writes only between pixels.
    assign in_stall  = !cmd.idle || cfg_valid;
    assign cfg_ready = cmd.idle;

endmodule
`default_nettype wire
